### rtl/quadratic_probe_hash_insert_unit_defines.svh
// assertion macros shared by the hash insert unit
`ifndef QUADRATIC_PROBE_HASH_INSERT_UNIT_DEFINES_SVH
`define QUADRATIC_PROBE_HASH_INSERT_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define QPH_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define QPH_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/qph_pkg.sv
// shared constants, types and helpers of the hash insert unit
`timescale 1ns / 1ps

package qph_pkg;

    localparam int SIZE_BITS     = 14;
    localparam int KEY_PORT_BITS = 16;
    localparam int TAG_BITS      = 16;
    localparam int SLOT_BITS     = 13;
    localparam int COLL_BITS     = 32;
    localparam int OCC_BITS      = 14;

    localparam int DEFAULT_TABLE_DEPTH = 8192;
    localparam int DEFAULT_KEY_BITS    = 16;

    localparam logic [SIZE_BITS-1:0] SIZE_RESET = 14'd8192;
    localparam logic [OCC_BITS-1:0]  OCC_MAX    = 14'h3FFF;
    localparam logic [COLL_BITS-1:0] COLL_MAX   = 32'hFFFF_FFFF;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // memory port controls from the sequencer
    typedef struct packed {
        logic wr_key;
        logic wr_tag;
        logic rd_en;
    } qph_mem_ctl_t;

    // stored key width: the key port never carries more than its own bits
    function automatic int key_width(input int kb);
        return (kb < KEY_PORT_BITS) ? kb : KEY_PORT_BITS;
    endfunction

endpackage

### rtl/qph_mod_unit.sv
// iterative remainder unit, one dividend bit per cycle
`timescale 1ns / 1ps

module qph_mod_unit
    import qph_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int KEY_BITS    = DEFAULT_KEY_BITS
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    input  logic [key_width(KEY_BITS)-1:0]          dividend,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0]        divisor,
    output logic                                    done,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]        remainder
);

    localparam int KW  = key_width(KEY_BITS);
    localparam int SZW = $clog2(TABLE_DEPTH+1);
    localparam int CW  = $clog2(KW);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [KW-1:0] quo_reg, quo_next;
    logic [SZW-1:0] div_reg, div_next;
    logic [SZW-1:0] rem_reg, rem_next;
    logic [SZW:0]   trial;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[KW-1]};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // restoring step: remainder stays below the divisor
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = SZW'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_next = SZW'(trial);
            end
            quo_next = {quo_reg[KW-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(KW-1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

### rtl/qph_slot_mem.sv
// slot key and name tag memories, one write and one registered read port
`timescale 1ns / 1ps

module qph_slot_mem
    import qph_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int KEY_BITS    = DEFAULT_KEY_BITS
)
(
    input  logic                                clk,
    input  qph_mem_ctl_t                        ctl,
    input  logic [$clog2(TABLE_DEPTH)-1:0]      wr_addr,
    input  logic [key_width(KEY_BITS)-1:0]      wr_key,
    input  logic [TAG_BITS-1:0]                 wr_tag,
    input  logic [$clog2(TABLE_DEPTH)-1:0]      rd_addr,
    output logic [key_width(KEY_BITS)-1:0]      rd_key
);

    localparam int KW = key_width(KEY_BITS);

    logic [KW-1:0]       key_mem [TABLE_DEPTH];
    logic [TAG_BITS-1:0] tag_mem [TABLE_DEPTH];
    logic [KW-1:0]       rd_key_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_key)
        begin
            key_mem[wr_addr] <= wr_key;
        end
        if (ctl.wr_tag)
        begin
            tag_mem[wr_addr] <= wr_tag;
        end
        if (ctl.rd_en)
        begin
            rd_key_reg <= key_mem[rd_addr];
        end
    end

    assign rd_key = rd_key_reg;

endmodule

### rtl/quadratic_probe_hash_insert_unit.sv
// top level of the quadratic probing hash insert unit
`timescale 1ns / 1ps

// Open-addressing hash table with quadratic probing, held in one synchronous
// key memory (plus a name tag memory) of TABLE_DEPTH slots. An insert beat
// first forms key mod size in an iterative remainder unit (one key bit per
// cycle, at most 16 key bits), then walks probe slots base + i*i mod size at
// one memory read per cycle; the read for the next probe goes out while the
// previous one is checked. A clear beat, and reset itself, run a clearing
// pass that writes one slot a cycle over all TABLE_DEPTH slots; no request
// is accepted during the pass, configuration writes are still taken. One
// item is worked at a time; the result sits in an output register, so the
// next request is accepted while a result still waits for the consumer. The
// user is to write the table size register through the cfg channel only while
// the unit is idle; the block itself does not enforce it. 0 acts as 1 and
// values above TABLE_DEPTH act as TABLE_DEPTH.

`include "quadratic_probe_hash_insert_unit_defines.svh"

module quadratic_probe_hash_insert_unit
    import qph_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int KEY_BITS    = DEFAULT_KEY_BITS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // config write channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [SIZE_BITS-1:0]      cfg_data,
    // request channel
    input  logic                      req_valid,
    output logic                      req_ready,
    input  logic                      operation,
    input  logic [KEY_PORT_BITS-1:0]  key_value,
    input  logic [TAG_BITS-1:0]       name_tag,
    // result channel
    output logic                      rsp_valid,
    input  logic                      rsp_ready,
    output logic [SLOT_BITS-1:0]      slot_index,
    output logic                      placed,
    output logic [COLL_BITS-1:0]      collision_total,
    output logic [OCC_BITS-1:0]       occupied_count
);

    localparam int KW  = key_width(KEY_BITS);
    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int SZW = $clog2(TABLE_DEPTH+1);

    typedef enum logic [4:0] {
        ST_SWEEP = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_MOD   = 5'b00100,
        ST_PROBE = 5'b01000,
        ST_DONE  = 5'b10000
    } qph_state_t;

    qph_state_t state_reg, state_next;

    // config and counters
    logic [SIZE_BITS-1:0] size_reg;
    logic [COLL_BITS-1:0] coll_reg, coll_next;
    logic [OCC_BITS-1:0]  occ_reg, occ_next;

    // item context
    logic [SZW-1:0] eff_size;
    logic [SZW-1:0] eff_reg, eff_next;
    logic [KW-1:0]  key_reg, key_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next;
    logic           sweep_item_reg, sweep_item_next;
    logic [AW-1:0]  sweep_addr_reg, sweep_addr_next;

    // probe walk
    logic [SZW-1:0] j_reg, j_next;
    logic [SZW-1:0] d_reg, d_next;
    logic [SZW-1:0] issued_reg, issued_next;
    logic [SZW-1:0] checked_reg, checked_next;
    logic           chk_valid_reg, chk_valid_next;
    logic [SZW-1:0] chk_addr_reg, chk_addr_next;
    logic           probe_issue;
    logic [SZW:0]   j_sum;
    logic [SZW:0]   d_sum;

    // result staging and output register
    logic [SZW-1:0]       res_slot_reg, res_slot_next;
    logic                 res_placed_reg, res_placed_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_load;
    logic [SLOT_BITS-1:0] out_slot_reg;
    logic                 out_placed_reg;
    logic [COLL_BITS-1:0] out_coll_reg;
    logic [OCC_BITS-1:0]  out_occ_reg;

    // memory and remainder unit hookup
    qph_mem_ctl_t   mem_ctl;
    logic [AW-1:0]  mem_wr_addr;
    logic [KW-1:0]  mem_wr_key;
    logic [AW-1:0]  mem_rd_addr;
    logic [KW-1:0]  mem_rd_key;
    logic           mod_start;
    logic           mod_done;
    logic [SZW-1:0] mod_rem;

    logic req_beat;

    assign cfg_ready = 1'b1;
    assign req_ready = (state_reg == ST_IDLE);
    assign req_beat  = req_valid && req_ready;

    // size actually used for hashing and probing
    always_comb
    begin
        if (size_reg == '0)
        begin
            eff_size = SZW'(1);
        end
        else if (32'(size_reg) > 32'(TABLE_DEPTH))
        begin
            eff_size = SZW'(TABLE_DEPTH);
        end
        else
        begin
            eff_size = SZW'(size_reg);
        end
    end

    qph_mod_unit #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (key_value[KW-1:0]),
        .divisor   (eff_size),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    qph_slot_mem #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS)
    ) u_mem (
        .clk     (clk),
        .ctl     (mem_ctl),
        .wr_addr (mem_wr_addr),
        .wr_key  (mem_wr_key),
        .wr_tag  (tag_reg),
        .rd_addr (mem_rd_addr),
        .rd_key  (mem_rd_key)
    );

    // next probe step: j += d, d += 2, both kept below the size
    always_comb
    begin
        j_sum = {1'b0, j_reg} + {1'b0, d_reg};
        d_sum = {1'b0, d_reg} + (SZW+1)'(2);
    end

    assign probe_issue = (state_reg == ST_PROBE) && (issued_reg < eff_reg);
    assign mem_rd_addr = j_reg[AW-1:0];

    always_comb
    begin
        state_next      = state_reg;
        coll_next       = coll_reg;
        occ_next        = occ_reg;
        eff_next        = eff_reg;
        key_next        = key_reg;
        tag_next        = tag_reg;
        sweep_item_next = sweep_item_reg;
        sweep_addr_next = sweep_addr_reg;
        j_next          = j_reg;
        d_next          = d_reg;
        issued_next     = issued_reg;
        checked_next    = checked_reg;
        chk_valid_next  = 1'b0;
        chk_addr_next   = chk_addr_reg;
        res_slot_next   = res_slot_reg;
        res_placed_next = res_placed_reg;
        mod_start       = 1'b0;
        out_load        = 1'b0;
        mem_ctl         = '0;
        mem_wr_addr     = chk_addr_reg[AW-1:0];
        mem_wr_key      = key_reg;

        case (state_reg)
            ST_SWEEP:
            begin
                mem_ctl.wr_key = 1'b1;
                mem_wr_addr    = sweep_addr_reg;
                mem_wr_key     = '0;
                sweep_addr_next = sweep_addr_reg + 1'b1;
                if (sweep_addr_reg == AW'(TABLE_DEPTH-1))
                begin
                    state_next = sweep_item_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_beat)
                begin
                    eff_next        = eff_size;
                    key_next        = key_value[KW-1:0];
                    tag_next        = name_tag;
                    res_slot_next   = '0;
                    res_placed_next = 1'b0;
                    if (operation == OP_CLEAR)
                    begin
                        coll_next       = '0;
                        occ_next        = '0;
                        sweep_item_next = 1'b1;
                        sweep_addr_next = '0;
                        state_next      = ST_SWEEP;
                    end
                    else
                    begin
                        mod_start  = 1'b1;
                        state_next = ST_MOD;
                    end
                end
            end
            ST_MOD:
            begin
                if (mod_done)
                begin
                    j_next       = mod_rem;
                    d_next       = (eff_reg == SZW'(1)) ? '0 : SZW'(1);
                    issued_next  = '0;
                    checked_next = '0;
                    state_next   = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                // issue the next read while the previous one is checked
                if (probe_issue)
                begin
                    mem_ctl.rd_en  = 1'b1;
                    chk_valid_next = 1'b1;
                    chk_addr_next  = j_reg;
                    issued_next    = issued_reg + 1'b1;
                    if (j_sum >= {1'b0, eff_reg})
                    begin
                        j_next = SZW'(j_sum - {1'b0, eff_reg});
                    end
                    else
                    begin
                        j_next = SZW'(j_sum);
                    end
                    if (eff_reg == SZW'(1))
                    begin
                        d_next = '0;
                    end
                    else if (d_sum >= {1'b0, eff_reg})
                    begin
                        d_next = SZW'(d_sum - {1'b0, eff_reg});
                    end
                    else
                    begin
                        d_next = SZW'(d_sum);
                    end
                end
                if (chk_valid_reg)
                begin
                    if (mem_rd_key == '0)
                    begin
                        // free slot: store and stop
                        mem_ctl.wr_key  = 1'b1;
                        mem_ctl.wr_tag  = 1'b1;
                        res_slot_next   = chk_addr_reg;
                        res_placed_next = 1'b1;
                        if ((key_reg != '0) && (occ_reg != OCC_MAX))
                        begin
                            occ_next = occ_reg + 1'b1;
                        end
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        if (coll_reg != COLL_MAX)
                        begin
                            coll_next = coll_reg + 1'b1;
                        end
                        checked_next = checked_reg + 1'b1;
                        // as many probes as slots in range, all found occupied
                        if (checked_next == eff_reg)
                        begin
                            res_slot_next   = '0;
                            res_placed_next = 1'b0;
                            state_next      = ST_DONE;
                        end
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SWEEP;
            size_reg       <= SIZE_RESET;
            coll_reg       <= '0;
            occ_reg        <= '0;
            sweep_item_reg <= 1'b0;
            sweep_addr_reg <= '0;
            chk_valid_reg  <= 1'b0;
            issued_reg     <= '0;
            checked_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            coll_reg       <= coll_next;
            occ_reg        <= occ_next;
            sweep_item_reg <= sweep_item_next;
            sweep_addr_reg <= sweep_addr_next;
            chk_valid_reg  <= chk_valid_next;
            issued_reg     <= issued_next;
            checked_reg    <= checked_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                size_reg <= cfg_data;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        eff_reg        <= eff_next;
        key_reg        <= key_next;
        tag_reg        <= tag_next;
        j_reg          <= j_next;
        d_reg          <= d_next;
        chk_addr_reg   <= chk_addr_next;
        res_slot_reg   <= res_slot_next;
        res_placed_reg <= res_placed_next;
        if (out_load)
        begin
            out_slot_reg   <= SLOT_BITS'(res_slot_reg);
            out_placed_reg <= res_placed_reg;
            out_coll_reg   <= coll_reg;
            out_occ_reg    <= occ_reg;
        end
    end

    assign rsp_valid       = out_valid_reg;
    assign slot_index      = out_slot_reg;
    assign placed          = out_placed_reg;
    assign collision_total = out_coll_reg;
    assign occupied_count  = out_occ_reg;

    // probe walk never runs past the table size
    `QPH_ASSERT_IMP(a_checked_in_range, clk, rst_n, (state_reg == ST_PROBE), (checked_reg < eff_reg), "probe check count reached table size while probing")
    // every probe read lands inside the table in use
    `QPH_ASSERT_IMP(a_probe_addr_in_range, clk, rst_n, probe_issue, (j_reg < eff_reg), "probe address outside table size")
    // occupancy cannot exceed the number of slots
    `QPH_ASSERT_IMP(a_occ_bound, clk, rst_n, 1'b1, (32'(occ_reg) <= 32'(TABLE_DEPTH)), "occupancy above table depth")
    // a pending result blocks the next one until it is taken
    `QPH_ASSERT_NXT(a_done_holds, clk, rst_n, ((state_reg == ST_DONE) && out_valid_reg && !rsp_ready), (state_reg == ST_DONE), "result overwrote a pending beat")

endmodule
